@@ hdl/kvh_pkg.sv @@
// Shared constants and types for the key/value hash table.
package kvh_pkg;

  // Default number of entries
  localparam int unsigned DEFAULT_CAPACITY = 1024;

  // Field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 11;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPSERT = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Slot marks: an empty slot ends a probe, a deleted one does not
  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_LIVE    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_mark_t;

  // One slot of the table memory
  typedef struct packed {
    slot_mark_t         mark;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

endpackage

@@ hdl/key_value_hash_table_core.sv @@
// Key/value hash table: open addressing with linear probing in one slot memory.
// Sequence: accept, then probing of P slots (P = slots visited, 1..CAPACITY),
//   then the result goes into the output register.
// Operations: one at a time; the probe loop over the single memory read port
//   sets the pace, and the next operation waits further while out_stall holds.
// Reset: synchronous; a clearing pass then marks every slot empty, one per cycle,
//   during which in_stall stays high.
module key_value_hash_table_core
  import kvh_pkg::*;
#(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [VALUE_W-1:0] out_value_out,
  output logic [COUNT_W-1:0] out_entry_count
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_EMIT
  } state_t;

  // Home slot: XOR fold of the key, reduced below CAPACITY
  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i += IDX_W) begin
      h ^= IDX_W'(k >> i);
    end
    if ({1'b0, h} >= (IDX_W+1)'(CAPACITY)) begin
      h = IDX_W'({1'b0, h} - (IDX_W+1)'(CAPACITY));
    end
    return h;
  endfunction

  state_t             state_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   probe_r;
  logic [IDX_W-1:0]   free_r;
  logic               have_free_r;
  logic [CNT_W-1:0]   count_r;
  logic [1:0]         res_status_r;
  logic               res_found_r;
  logic [VALUE_W-1:0] res_value_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_found_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0] out_count_r;

  slot_t              mem [CAPACITY];
  slot_t              rd_q_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  slot_t              mem_wdata;

  logic [IDX_W-1:0]   idx_inc;
  logic               slot_match;
  logic               slot_empty;
  logic               probe_last;
  logic               probe_done;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic               in_acc;
  logic               out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Probe step decode on the slot read last cycle
  assign idx_inc    = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  assign slot_match = (rd_q_r.mark == SLOT_LIVE) && (rd_q_r.key == key_r);
  assign slot_empty = (rd_q_r.mark == SLOT_EMPTY);
  assign probe_last = (probe_r == LAST_IDX);
  assign probe_done = slot_match || slot_empty || probe_last;
  assign free_ok    = have_free_r || (rd_q_r.mark != SLOT_LIVE);
  assign free_idx   = have_free_r ? free_r : idx_r;
  assign rd_addr    = (state_r == S_IDLE) ? home_slot(in_key) : idx_inc;

  // Memory write select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '{mark: SLOT_LIVE, key: key_r, value: val_r};
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '{mark: SLOT_EMPTY, key: '0, value: '0};
      end
      S_PROBE: begin
        if (probe_done) begin
          if (slot_match) begin
            if (op_r == OP_UPSERT) begin
              mem_we = 1'b1;
            end else if (op_r == OP_REMOVE) begin
              mem_we    = 1'b1;
              mem_wdata = '{mark: SLOT_DELETED, key: rd_q_r.key, value: rd_q_r.value};
            end
          end else if ((op_r == OP_INSERT || op_r == OP_UPSERT) && free_ok) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      have_free_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Result beat loads on emit, holds while stalled
      out_valid_r <= ((state_r == S_EMIT) && out_free) || (out_valid_r && out_stall);
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r        <= in_opcode;
            key_r       <= in_key;
            val_r       <= in_value_in;
            idx_r       <= rd_addr;
            probe_r     <= '0;
            have_free_r <= 1'b0;
            state_r     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!probe_done) begin
            if (!have_free_r && rd_q_r.mark != SLOT_LIVE) begin
              have_free_r <= 1'b1;
              free_r      <= idx_r;
            end
            idx_r   <= idx_inc;
            probe_r <= probe_r + IDX_W'(1);
          end else begin
            state_r     <= S_EMIT;
            res_found_r <= slot_match;
            res_value_r <= (slot_match && op_r == OP_LOOKUP) ? rd_q_r.value : '0;
            if (slot_match) begin
              unique case (op_r)
                OP_LOOKUP: res_status_r <= ST_OK;
                OP_INSERT: res_status_r <= ST_PRESENT;
                OP_UPSERT: res_status_r <= ST_OK;
                OP_REMOVE: begin
                  res_status_r <= ST_OK;
                  count_r      <= count_r - CNT_W'(1);
                end
                default: res_status_r <= ST_OK;
              endcase
            end else if (op_r == OP_LOOKUP || op_r == OP_REMOVE) begin
              res_status_r <= ST_ABSENT;
            end else if (free_ok) begin
              res_status_r <= ST_OK;
              count_r      <= count_r + CNT_W'(1);
            end else begin
              res_status_r <= ST_FULL;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_found_r  <= res_found_r;
            out_value_r  <= res_value_r;
            out_count_r  <= COUNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;

endmodule

@@ hdl/kvh_checker.sv @@
// Port-level checks for the key/value hash table, bound to the top level.
module kvh_checker
  import kvh_pkg::*;
#(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic               out_found,
  input logic [VALUE_W-1:0] out_value_out,
  input logic [COUNT_W-1:0] out_entry_count
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_value_out)
      && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // Value only on a successful hit
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_found || out_status != ST_OK) |-> out_value_out == '0)
    else $error("value_out nonzero without a hit");

  // Found and status agree
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK || out_status == ST_PRESENT)
    else $error("found with absent or full status");

  // Full only when the count is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == COUNT_W'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind key_value_hash_table_core kvh_checker #(.CAPACITY(CAPACITY)) u_kvh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_value_out   (out_value_out),
  .out_entry_count (out_entry_count)
);
